// ===== rtl/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// crd_pkg
// shared constants for the camera ray direction unit
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int EXTRA_BITS = 10;
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int COMP_W     = 16;
    localparam int AXIS_W     = 3 * COMP_W;
    localparam int INDEX_W    = 3;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] REG_RIGHT_AXIS   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_UP_AXIS      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_FORWARD_AXIS = 3'd2;
    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/crd_div_pipe.sv =====
// ----------------------------------------------------------------------------
// crd_div_pipe
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module crd_div_pipe #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 13,
    parameter int QUO_W = 15
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] num_w [QUO_W+1];
    logic [DEN_W-1:0] den_w [QUO_W+1];
    logic [QUO_W-1:0] quo_w [QUO_W+1];

    logic [NUM_W-1:0] num_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    assign num_w[0] = num;
    assign den_w[0] = den;
    assign quo_w[0] = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [CMP_W-1:0] trial;
        logic [NUM_W-1:0] num_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            trial    = CMP_W'(den_w[k]) << (QUO_W - 1 - k);
            num_next = num_w[k];
            quo_next = quo_w[k];
            if (CMP_W'(num_w[k]) >= trial)
            begin
                num_next = num_w[k] - trial[NUM_W-1:0];
                quo_next[QUO_W-1-k] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= num_next;
                den_reg[k] <= den_w[k];
                quo_reg[k] <= quo_next;
            end
        end

        assign num_w[k+1] = num_reg[k];
        assign den_w[k+1] = den_reg[k];
        assign quo_w[k+1] = quo_reg[k];
    end

    assign quo = quo_w[QUO_W];

endmodule

`default_nettype wire

// ===== rtl/crd_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// crd_sqrt_pipe
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module crd_sqrt_pipe #(
    parameter int RAD_W = 56
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [RAD_W-1:0]   rad,
    output logic      [RAD_W/2-1:0] root
);

    localparam int STEPS = RAD_W / 2;

    logic [RAD_W-1:0] n_w   [STEPS+1];
    logic [RAD_W-1:0] res_w [STEPS+1];
    logic [RAD_W-1:0] n_reg   [STEPS];
    logic [RAD_W-1:0] res_reg [STEPS];

    assign n_w[0]   = rad;
    assign res_w[0] = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [RAD_W-1:0] bitv;
        logic [RAD_W-1:0] trial;
        logic [RAD_W-1:0] n_next;
        logic [RAD_W-1:0] res_next;

        always_comb
        begin
            bitv     = RAD_W'(1) << (RAD_W - 2 - 2 * k);
            trial    = res_w[k] + bitv;
            n_next   = n_w[k];
            res_next = res_w[k] >> 1;
            if (n_w[k] >= trial)
            begin
                n_next   = n_w[k] - trial;
                res_next = (res_w[k] >> 1) + bitv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= n_next;
                res_reg[k] <= res_next;
            end
        end

        assign n_w[k+1]   = n_reg[k];
        assign res_w[k+1] = res_reg[k];
    end

    assign root = res_w[STEPS][STEPS-1:0];

endmodule

`default_nettype wire

// ===== rtl/camera_ray_direction_unit.sv =====
// ----------------------------------------------------------------------------
// camera_ray_direction_unit
// pinhole camera ray generator: pixel coordinate in, unit Q1.14 direction out
// ----------------------------------------------------------------------------
// One item enters per clock and the block sustains one item per cycle while
// the output is not stalled. The pipeline is built from bit-serial units laid
// out as stages: a 15-stage divider that normalizes the coordinates, a
// 28-stage square root of the squared length and a 15-stage normalizing
// divider per component, plus input, multiply, sum, square, squared-length
// and output stages. The whole pipeline advances together; it holds only when
// a finished item sits in the output register and out_ready is low, so input
// is taken while results wait as long as the output register is free to
// move. Configuration writes must land while the pipeline is empty; the
// axis and resolution registers are read directly by the stages.
`default_nettype none

module camera_ray_direction_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration
    input  wire logic                                 wr_en,
    input  wire logic [crd_pkg::INDEX_W-1:0]          wr_index,
    input  wire logic [crd_pkg::AXIS_W-1:0]           wr_data,
    // pixel item
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [crd_pkg::COORD_W-1:0]          pixel_x,
    input  wire logic [crd_pkg::COORD_W-1:0]          pixel_y,
    // direction item
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [crd_pkg::COMP_W-1:0]         dir_x,
    output logic signed [crd_pkg::COMP_W-1:0]         dir_y,
    output logic signed [crd_pkg::COMP_W-1:0]         dir_z,
    output logic                                      coord_out_of_range
);

    localparam int LAT      = 64;   // total register stages
    localparam int DIVA_LAT = 15;   // coordinate divider
    localparam int SQRT_LAT = 28;   // root of a 56-bit radicand
    localparam int DIVB_LAT = 15;   // normalizing divider
    localparam int NUM_W    = 28;
    localparam int MAG_W    = 17;
    localparam int V_W      = 18;
    localparam int SQ_W     = 36;
    localparam int ROOT_W   = 28;
    localparam int NB_W     = 42;
    localparam logic [crd_pkg::COMP_W-1:0] ONE = 16'd16384;

    typedef struct packed {
        logic                        oor;
        logic                        zero;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
    } side_t;

    typedef struct packed {
        logic       oor;
        logic       zero;
        logic [2:0] neg;
    } tail_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [crd_pkg::AXIS_W-1:0] right_reg, up_reg, fwd_reg;
    logic [crd_pkg::DIM_W-1:0]  width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg  <= 48'd16384;
            up_reg     <= 48'd1073741824;
            fwd_reg    <= 48'd70368744177664;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                crd_pkg::REG_RIGHT_AXIS:   right_reg  <= wr_data;
                crd_pkg::REG_UP_AXIS:      up_reg     <= wr_data;
                crd_pkg::REG_FORWARD_AXIS: fwd_reg    <= wr_data;
                crd_pkg::REG_IMAGE_WIDTH:  width_reg  <= wr_data[crd_pkg::DIM_W-1:0];
                crd_pkg::REG_IMAGE_HEIGHT: height_reg <= wr_data[crd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: one shared advance, valid bits shift with data
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // stage 0: clamp resolution and coordinate, form division operands
    // ------------------------------------------------------------------
    logic [crd_pkg::DIM_W-1:0]   w_clamp, h_clamp;
    logic [crd_pkg::COORD_W-1:0] w_m1, h_m1, px, py;
    logic                        oor_next;

    function automatic logic [crd_pkg::DIM_W-1:0] clamp_dim(
        input logic [crd_pkg::DIM_W-1:0] r
    );
        if (r < 13'd2)
            return 13'd2;
        else if (r > 13'(crd_pkg::MAX_DIM))
            return 13'(crd_pkg::MAX_DIM);
        else
            return r;
    endfunction

    always_comb
    begin
        w_clamp  = clamp_dim(width_reg);
        h_clamp  = clamp_dim(height_reg);
        w_m1     = 12'(w_clamp - 13'd1);
        h_m1     = 12'(h_clamp - 13'd1);
        oor_next = 1'b0;
        px       = pixel_x;
        py       = pixel_y;
        if ({1'b0, pixel_x} >= w_clamp)
        begin
            oor_next = 1'b1;
            px       = w_m1;
        end
        if ({1'b0, pixel_y} >= h_clamp)
        begin
            oor_next = 1'b1;
            py       = h_m1;
        end
    end

    logic [NUM_W-1:0]          numx_reg, numy_reg;
    logic [crd_pkg::DIM_W-1:0] denx_reg, deny_reg;
    logic                      oor0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // round half up: (c * 2^15 + (res-1)) / (2 * (res-1))
            numx_reg <= {1'b0, px, 15'd0} + NUM_W'(w_m1);
            numy_reg <= {1'b0, py, 15'd0} + NUM_W'(h_m1);
            denx_reg <= {w_m1, 1'b0};
            deny_reg <= {h_m1, 1'b0};
            oor0_reg <= oor_next;
        end
    end

    logic [DIVA_LAT-1:0] qx, qy;

    crd_div_pipe #(.NUM_W(NUM_W), .DEN_W(crd_pkg::DIM_W), .QUO_W(DIVA_LAT)) u_divx (
        .clk (clk),
        .en  (adv),
        .num (numx_reg),
        .den (denx_reg),
        .quo (qx)
    );

    crd_div_pipe #(.NUM_W(NUM_W), .DEN_W(crd_pkg::DIM_W), .QUO_W(DIVA_LAT)) u_divy (
        .clk (clk),
        .en  (adv),
        .num (numy_reg),
        .den (deny_reg),
        .quo (qy)
    );

    // flag rides alongside the coordinate divider
    logic oor_a_reg [DIVA_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oor_a_reg[0] <= oor0_reg;
            for (int i = 1; i < DIVA_LAT; i++)
                oor_a_reg[i] <= oor_a_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // multiply by the axes, then sum with the forward axis
    // ------------------------------------------------------------------
    logic signed [15:0] xn, yn;

    assign xn = $signed({1'b0, qx}) - 16'sd8192;
    assign yn = $signed({1'b0, qy}) - 16'sd8192;

    logic signed [31:0] pr_reg [3];
    logic signed [31:0] pu_reg [3];
    logic               oor1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= xn * $signed(right_reg[i*16 +: 16]);
                pu_reg[i] <= yn * $signed(up_reg[i*16 +: 16]);
            end
            oor1_reg <= oor_a_reg[DIVA_LAT-1];
        end
    end

    logic signed [V_W-1:0] v_reg [3];
    logic                  oor2_reg;
    logic signed [32:0]    psum [3];
    logic signed [19:0]    vsum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = 33'(pr_reg[i]) + 33'(pu_reg[i]) + 33'sd8192;
            // arithmetic shift floors toward minus infinity
            vsum[i] = $signed({psum[i][32], psum[i][32:14]})
                    + 20'($signed(fwd_reg[i*16 +: 16]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                v_reg[i] <= vsum[i][V_W-1:0];
            oor2_reg <= oor1_reg;
        end
    end

    // ------------------------------------------------------------------
    // squares, magnitudes, then squared length
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]  sq_reg [3];
    logic [2:0]       neg3_reg;
    logic [MAG_W-1:0] mag3_reg [3];
    logic             oor3_reg;
    logic [V_W-1:0]   vabs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            vabs[i] = v_reg[i][V_W-1] ? V_W'(-v_reg[i]) : V_W'(v_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= SQ_W'(v_reg[i] * v_reg[i]);
                neg3_reg[i] <= v_reg[i][V_W-1];
                mag3_reg[i] <= vabs[i][MAG_W-1:0];
            end
            oor3_reg <= oor2_reg;
        end
    end

    logic [SQ_W-1:0] s_reg;
    side_t           side4_reg;
    logic [SQ_W-1:0] s_next;

    assign s_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg          <= s_next;
            side4_reg.oor  <= oor3_reg;
            side4_reg.zero <= (s_next == '0);
            side4_reg.neg  <= neg3_reg;
            for (int i = 0; i < 3; i++)
                side4_reg.mag[i] <= mag3_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // length: floor(sqrt(S * 2^20))
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] droot;

    crd_sqrt_pipe #(.RAD_W(2 * ROOT_W)) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  ({s_reg, 20'd0}),
        .root (droot)
    );

    side_t side_dly_reg [SQRT_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_dly_reg[0] <= side4_reg;
            for (int i = 1; i < SQRT_LAT; i++)
                side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // per-component rounded division by the length
    // ------------------------------------------------------------------
    side_t           side_s;
    logic [2:0][DIVB_LAT-1:0] qd;

    assign side_s = side_dly_reg[SQRT_LAT-1];

    for (genvar c = 0; c < 3; c++) begin : g_norm
        logic [NB_W-1:0] nb;

        assign nb = NB_W'({side_s.mag[c], 24'd0}) + NB_W'(droot[ROOT_W-1:1]);

        crd_div_pipe #(.NUM_W(NB_W), .DEN_W(ROOT_W), .QUO_W(DIVB_LAT)) u_div (
            .clk (clk),
            .en  (adv),
            .num (nb),
            .den (droot),
            .quo (qd[c])
        );
    end

    tail_t tail_dly_reg [DIVB_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_dly_reg[0] <= '{oor: side_s.oor, zero: side_s.zero, neg: side_s.neg};
            for (int i = 1; i < DIVB_LAT; i++)
                tail_dly_reg[i] <= tail_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // output register: clamp to one, apply sign, zero vector gives zeros
    // ------------------------------------------------------------------
    tail_t                     tail_s;
    logic [2:0][crd_pkg::COMP_W-1:0] dir_next;
    logic [crd_pkg::COMP_W-1:0]      qc;

    assign tail_s = tail_dly_reg[DIVB_LAT-1];

    always_comb
    begin
        qc = '0;
        for (int i = 0; i < 3; i++)
        begin
            qc = (16'(qd[i]) > ONE) ? ONE : 16'(qd[i]);
            if (tail_s.zero)
                dir_next[i] = '0;
            else if (tail_s.neg[i])
                dir_next[i] = 16'(-qc);
            else
                dir_next[i] = qc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_x              <= $signed(dir_next[0]);
            dir_y              <= $signed(dir_next[1]);
            dir_z              <= $signed(dir_next[2]);
            coord_out_of_range <= tail_s.oor;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dir_x <= 16'sd16384) && (dir_x >= -16'sd16384)
                   && (dir_y <= 16'sd16384) && (dir_y >= -16'sd16384)
                   && (dir_z <= 16'sd16384) && (dir_z >= -16'sd16384))
        else $error("direction component beyond one");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[LAT-2] && tail_s.zero |=> dir_x == 0 && dir_y == 0 && dir_z == 0)
        else $error("zero vector produced a nonzero direction");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks camera_ray_direction_unit ray directions against a local predictor
// under directed and random pixel items, random bursts on the input and random output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    // pipeline depth (LAT in the block), then drain time with margin
    localparam int PIPE_CYCLES = 64;
    localparam int DRAIN_CYCLES = PIPE_CYCLES + 16;

    typedef struct packed {
        logic [crd_pkg::COORD_W-1:0] px;
        logic [crd_pkg::COORD_W-1:0] py;
    } pixel_t;

    typedef struct packed {
        logic signed [crd_pkg::COMP_W-1:0] dx;
        logic signed [crd_pkg::COMP_W-1:0] dy;
        logic signed [crd_pkg::COMP_W-1:0] dz;
        logic                              oor;
    } ray_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [crd_pkg::INDEX_W-1:0] wr_index;
    logic [crd_pkg::AXIS_W-1:0] wr_data;
    logic in_valid;
    logic in_ready;
    logic [crd_pkg::COORD_W-1:0] pixel_x;
    logic [crd_pkg::COORD_W-1:0] pixel_y;
    logic out_valid;
    logic out_ready;
    logic signed [crd_pkg::COMP_W-1:0] dir_x;
    logic signed [crd_pkg::COMP_W-1:0] dir_y;
    logic signed [crd_pkg::COMP_W-1:0] dir_z;
    logic coord_out_of_range;

    camera_ray_direction_unit dut (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .coord_out_of_range(coord_out_of_range)
    );

    // local copy of the configuration registers
    logic [crd_pkg::AXIS_W-1:0] cam_right;
    logic [crd_pkg::AXIS_W-1:0] cam_up;
    logic [crd_pkg::AXIS_W-1:0] cam_fwd;
    logic [crd_pkg::DIM_W-1:0]  cam_width;
    logic [crd_pkg::DIM_W-1:0]  cam_height;

    pixel_t pending_pixels[$];
    ray_t   expected_rays[$];
    int     mismatch_count = 0;
    logic   stim_done = 0;

    // sender burst / gap state and receiver stall pattern
    int burst_left = 0;
    int gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int stall_pos = 0;

    always #4 clk = ~clk;

    task automatic queue_pixel(input pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    task automatic queue_ray(input ray_t r);
        expected_rays.insert(expected_rays.size(), r);
    endtask

    function automatic longint axis_comp(logic [crd_pkg::AXIS_W-1:0] r, int i);
        logic signed [crd_pkg::COMP_W-1:0] f;
        f = r[crd_pkg::COMP_W*i +: crd_pkg::COMP_W];
        return longint'(f);
    endfunction

    function automatic longint clamp_res(logic [crd_pkg::DIM_W-1:0] r);
        if (r < 2) return 2;
        if (r > crd_pkg::MAX_DIM) return crd_pkg::MAX_DIM;
        return longint'(r);
    endfunction

    // coordinate to Q.F in -1/2 .. 1/2, rounded half up
    function automatic longint coord_to_q(longint c, longint res);
        longint den;
        den = res - 1;
        return ((c <<< (crd_pkg::FRAC_BITS + 1)) + den) / (2 * den)
             - (longint'(1) <<< (crd_pkg::FRAC_BITS - 1));
    endfunction

    function automatic longint floor_q(longint p);
        if (p >= 0) return p >>> crd_pkg::FRAC_BITS;
        return -((-p + (longint'(1) <<< crd_pkg::FRAC_BITS) - 1) >>> crd_pkg::FRAC_BITS);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic ray_t predict_ray(pixel_t p);
        ray_t r;
        longint w, h, cx, cy, xn, yn, prod;
        longint v[3];
        longint unsigned sum, d, mag, q;
        w = clamp_res(cam_width);
        h = clamp_res(cam_height);
        cx = p.px;
        cy = p.py;
        r.oor = 0;
        if (cx >= w) begin r.oor = 1; cx = w - 1; end
        if (cy >= h) begin r.oor = 1; cy = h - 1; end
        xn = coord_to_q(cx, w);
        yn = coord_to_q(cy, h);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            prod = xn * axis_comp(cam_right, i) + yn * axis_comp(cam_up, i)
                 + (longint'(1) <<< (crd_pkg::FRAC_BITS - 1));
            v[i] = floor_q(prod) + axis_comp(cam_fwd, i);
            sum += longint'(v[i] * v[i]);
        end
        r.dx = 0; r.dy = 0; r.dz = 0;
        // zero vector gives an all-zero direction
        if (sum != 0) begin
            d = int_sqrt(sum << (2 * crd_pkg::EXTRA_BITS));
            for (int i = 0; i < 3; i++) begin
                mag = (v[i] < 0) ? -v[i] : v[i];
                q = ((mag << (crd_pkg::FRAC_BITS + crd_pkg::EXTRA_BITS)) + d / 2) / d;
                if (q > (64'd1 << crd_pkg::FRAC_BITS)) q = 64'd1 << crd_pkg::FRAC_BITS;
                if (v[i] < 0) q = -q;
                if (i == 0) r.dx = q[crd_pkg::COMP_W-1:0];
                else if (i == 1) r.dy = q[crd_pkg::COMP_W-1:0];
                else r.dz = q[crd_pkg::COMP_W-1:0];
            end
        end
        return r;
    endfunction

    // driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            pixel_x <= 0;
            pixel_y <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            // previous item taken (or none held): decide on the next one
            if (in_valid)
                queue_ray(predict_ray('{pixel_x, pixel_y}));
            if (gap_left > 0 || pending_pixels.size() == 0)
            begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                in_valid <= 0;
            end
            else
            begin
                pixel_t nxt;
                nxt = pending_pixels.pop_front();
                in_valid <= 1;
                pixel_x <= nxt.px;
                pixel_y <= nxt.py;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(40, 0);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rays.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected item: %0d %0d %0d %0b",
                                 dir_x, dir_y, dir_z, coord_out_of_range);
                end
                else
                begin
                    ray_t e;
                    e = expected_rays.pop_front();
                    if (e.dx !== dir_x || e.dy !== dir_y || e.dz !== dir_z
                        || e.oor !== coord_out_of_range)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                     e.dx, e.dy, e.dz, e.oor,
                                     dir_x, dir_y, dir_z, coord_out_of_range);
                    end
                end
            end
            if (stall_pos == 15)
            begin
                stall_pos <= 0;
                // one pattern in four is stall free
                stall_pattern <= ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom);
            end
            else
            begin
                stall_pos <= stall_pos + 1;
            end
            out_ready <= stall_pattern[stall_pos];
        end
    end

    // one write per call, with wr_en dropped before returning, so enables never pile up in one step
    task automatic write_reg(input logic [crd_pkg::INDEX_W-1:0] idx,
                             input logic [crd_pkg::AXIS_W-1:0] val);
        wr_en <= 1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 0;
        case (idx)
            crd_pkg::REG_RIGHT_AXIS:   cam_right = val;
            crd_pkg::REG_UP_AXIS:      cam_up = val;
            crd_pkg::REG_FORWARD_AXIS: cam_fwd = val;
            crd_pkg::REG_IMAGE_WIDTH:  cam_width = val[crd_pkg::DIM_W-1:0];
            crd_pkg::REG_IMAGE_HEIGHT: cam_height = val[crd_pkg::DIM_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // wait until all items are taken and all results are checked
    task automatic drain();
        while (pending_pixels.size() != 0 || in_valid || expected_rays.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [crd_pkg::COMP_W-1:0] rand_comp();
        case ($urandom_range(5, 0))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom_range(32767, 0) - 16384);
        endcase
    endfunction

    function automatic logic [crd_pkg::AXIS_W-1:0] rand_axis();
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    function automatic logic [crd_pkg::DIM_W-1:0] rand_dim();
        case ($urandom_range(7, 0))
            0: return 13'd2;
            1: return 13'd4096;
            2: return 13'($urandom_range(1, 0));
            3: return 13'($urandom_range(8191, 4097));
            default: return 13'($urandom_range(300, 2));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        // mostly inside the image, some beyond
        if ($urandom_range(7, 0) == 0)
        begin
            p.px = 12'($urandom);
            p.py = 12'($urandom);
        end
        else
        begin
            p.px = 12'($urandom_range(32'(clamp_res(cam_width) - 1), 0));
            p.py = 12'($urandom_range(32'(clamp_res(cam_height) - 1), 0));
        end
        return p;
    endfunction

    initial
    begin
        clk = 0;
        rst_n = 0;
        wr_en = 0;
        wr_index = 0;
        wr_data = 0;
        cam_right = 48'd16384;
        cam_up = 48'd1073741824;
        cam_fwd = 48'd70368744177664;
        cam_width = 640;
        cam_height = 480;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset configuration, corners, center and overflow
        queue_pixel('{12'd0, 12'd0});
        queue_pixel('{12'd639, 12'd479});
        queue_pixel('{12'd320, 12'd240});
        queue_pixel('{12'd640, 12'd0});
        queue_pixel('{12'd0, 12'd480});
        queue_pixel('{12'd4095, 12'd4095});
        queue_pixel('{12'hAAA, 12'h555});
        queue_pixel('{12'h555, 12'hAAA});
        drain();

        // extreme resolutions and axes
        write_reg(crd_pkg::REG_IMAGE_WIDTH, 48'd4096);
        write_reg(crd_pkg::REG_IMAGE_HEIGHT, 48'd2);
        write_reg(crd_pkg::REG_RIGHT_AXIS, {16'h8000, 16'h8000, 16'h8000});
        write_reg(crd_pkg::REG_UP_AXIS, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        queue_pixel('{12'd4095, 12'd1});
        queue_pixel('{12'd0, 12'd0});
        queue_pixel('{12'd2048, 12'd2});
        drain();

        // width below minimum, height above maximum, index beyond the list
        write_reg(crd_pkg::REG_IMAGE_WIDTH, 48'd0);
        write_reg(crd_pkg::REG_IMAGE_HEIGHT, 48'h1FFF);
        write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
        write_reg(crd_pkg::REG_FORWARD_AXIS, 48'hFFFF_FFFF_FFFF);
        queue_pixel('{12'd1, 12'd4095});
        queue_pixel('{12'd0, 12'd2048});
        drain();

        // zero vector: all axes zero
        write_reg(crd_pkg::REG_RIGHT_AXIS, 48'd0);
        write_reg(crd_pkg::REG_UP_AXIS, 48'd0);
        write_reg(crd_pkg::REG_FORWARD_AXIS, 48'd0);
        queue_pixel('{12'd1, 12'd1});
        queue_pixel('{12'd0, 12'd4000});
        drain();

        // random phases, each with a fresh configuration
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(crd_pkg::REG_RIGHT_AXIS, rand_axis());
            write_reg(crd_pkg::REG_UP_AXIS, rand_axis());
            write_reg(crd_pkg::REG_FORWARD_AXIS, rand_axis());
            write_reg(crd_pkg::REG_IMAGE_WIDTH, 48'(rand_dim()));
            write_reg(crd_pkg::REG_IMAGE_HEIGHT, 48'(rand_dim()));
            for (int k = 0; k < 100; k++)
                queue_pixel(rand_pixel());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (mismatch_count == 0 && expected_rays.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/crd_pkg.sv
rtl/crd_div_pipe.sv
rtl/crd_sqrt_pipe.sv
rtl/camera_ray_direction_unit.sv
dv/testbench.sv
